FILE: rtl/bli_pkg.sv
// ----------------------------------------------------------------------------
// bli_pkg
// shared types, register indexes, operation codes and reset values
// ----------------------------------------------------------------------------
package bli_pkg;

  localparam int SAMPLE_BITS = 8;
  localparam int CFG_TIME_BITS = 12;
  localparam int CFG_DATA_BITS = 12;
  localparam int CFG_INDEX_BITS = 3;
  localparam int PULSE_BITS = 4;
  localparam int TIMER_BITS_DEFAULT = 12;

  localparam logic [SAMPLE_BITS-1:0] LOW_THRESHOLD_RESET = 8'd50;
  localparam logic [CFG_TIME_BITS-1:0] BLINK_SHORT_RESET = 12'd100;
  localparam logic [CFG_TIME_BITS-1:0] BLINK_PAUSE_RESET = 12'd1500;
  localparam logic [PULSE_BITS-1:0] BLINKS_PER_BURST_RESET = 4'd3;
  localparam logic [CFG_TIME_BITS-1:0] CHARGE_BLINK_RESET = 12'd500;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_SAMPLE = 2'd1,
    OP_PIN    = 2'd2
  } op_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_LOW_THRESHOLD    = 3'd0,
    REG_CHARGE_ENABLE    = 3'd1,
    REG_OFFSET_ENABLE    = 3'd2,
    REG_BLINK_SHORT      = 3'd3,
    REG_BLINK_PAUSE      = 3'd4,
    REG_BLINKS_PER_BURST = 3'd5,
    REG_CHARGE_BLINK     = 3'd6
  } reg_index_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0]   low_threshold;
    logic                     charge_enable;
    logic                     offset_enable;
    logic [CFG_TIME_BITS-1:0] blink_short_ms;
    logic [CFG_TIME_BITS-1:0] blink_pause_ms;
    logic [PULSE_BITS-1:0]    blinks_per_burst;
    logic [CFG_TIME_BITS-1:0] charge_blink_ms;
  } cfg_t;

  typedef struct packed {
    logic                   led_on;
    logic [SAMPLE_BITS-1:0] battery_level;
    logic                   level_update;
    logic                   battery_low;
    logic                   charging;
  } result_t;

endpackage

FILE: rtl/bli_cfg.sv
// ----------------------------------------------------------------------------
// bli_cfg
// configuration register file, written by index, no read-back
// ----------------------------------------------------------------------------
module bli_cfg
  import bli_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  output cfg_t                      cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.low_threshold    <= LOW_THRESHOLD_RESET;
      cfg.charge_enable    <= 1'b0;
      cfg.offset_enable    <= 1'b1;
      cfg.blink_short_ms   <= BLINK_SHORT_RESET;
      cfg.blink_pause_ms   <= BLINK_PAUSE_RESET;
      cfg.blinks_per_burst <= BLINKS_PER_BURST_RESET;
      cfg.charge_blink_ms  <= CHARGE_BLINK_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_LOW_THRESHOLD:    cfg.low_threshold    <= cfg_data[SAMPLE_BITS-1:0];
        REG_CHARGE_ENABLE:    cfg.charge_enable    <= cfg_data[0];
        REG_OFFSET_ENABLE:    cfg.offset_enable    <= cfg_data[0];
        REG_BLINK_SHORT:      cfg.blink_short_ms   <= cfg_data[CFG_TIME_BITS-1:0];
        REG_BLINK_PAUSE:      cfg.blink_pause_ms   <= cfg_data[CFG_TIME_BITS-1:0];
        REG_BLINKS_PER_BURST: cfg.blinks_per_burst <= cfg_data[PULSE_BITS-1:0];
        REG_CHARGE_BLINK:     cfg.charge_blink_ms  <= cfg_data[CFG_TIME_BITS-1:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/bli_engine.sv
// ----------------------------------------------------------------------------
// bli_engine
// level, offset, blink and charge timer state with one-pass event update
// ----------------------------------------------------------------------------
module bli_engine
  import bli_pkg::*;
#(
  parameter int TIMER_BITS = TIMER_BITS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  cfg_t                   cfg,
  input  logic                   step,
  input  logic [1:0]             op,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  logic                   present,
  output result_t                result
);

  logic                   led_state, led_state_next;
  logic [SAMPLE_BITS-1:0] stored_level, stored_level_next;
  logic [SAMPLE_BITS-1:0] offset_counter, offset_counter_next;
  logic [PULSE_BITS-1:0]  pulses_left, pulses_left_next;
  logic [TIMER_BITS-1:0]  blink_rem, blink_rem_next;
  logic                   blink_armed, blink_armed_next;
  logic [TIMER_BITS-1:0]  charge_rem, charge_rem_next;
  logic                   charge_armed, charge_armed_next;
  logic                   charger_level, charger_level_next;
  logic                   changed;
  logic [SAMPLE_BITS-1:0] level;
  logic                   led_mid;
  logic [TIMER_BITS-1:0]  short_load, pause_load, charge_load;

  assign short_load  = TIMER_BITS'(cfg.blink_short_ms);
  assign pause_load  = TIMER_BITS'(cfg.blink_pause_ms);
  assign charge_load = TIMER_BITS'(cfg.charge_blink_ms);
  assign level = cfg.offset_enable ? sample + offset_counter : sample;

  always_comb begin
    led_state_next      = led_state;
    stored_level_next   = stored_level;
    offset_counter_next = offset_counter;
    pulses_left_next    = pulses_left;
    blink_rem_next      = blink_rem;
    blink_armed_next    = blink_armed;
    charge_rem_next     = charge_rem;
    charge_armed_next   = charge_armed;
    charger_level_next  = charger_level;
    changed             = 1'b0;
    led_mid             = led_state;
    case (op)
      OP_TICK: begin
        // blink timer first, charge timer sees its led result
        if (blink_armed) begin
          if (blink_rem <= TIMER_BITS'(1)) begin
            if (stored_level >= cfg.low_threshold) begin
              led_mid          = 1'b1;
              blink_rem_next   = '0;
              blink_armed_next = 1'b0;
            end else if (pulses_left != '0) begin
              led_mid        = ~led_state;
              blink_rem_next = short_load;
              if (!led_state) begin
                pulses_left_next = pulses_left - PULSE_BITS'(1);
              end
            end else begin
              pulses_left_next = cfg.blinks_per_burst;
              led_mid          = 1'b0;
              blink_rem_next   = pause_load;
            end
          end else begin
            blink_rem_next = blink_rem - TIMER_BITS'(1);
          end
        end
        led_state_next = led_mid;
        if (charge_armed) begin
          if (charge_rem <= TIMER_BITS'(1)) begin
            if (cfg.charge_enable) begin
              led_state_next  = ~led_mid;
              charge_rem_next = charge_load;
            end else begin
              charge_rem_next   = '0;
              charge_armed_next = 1'b0;
            end
          end else begin
            charge_rem_next = charge_rem - TIMER_BITS'(1);
          end
        end
      end
      OP_SAMPLE: begin
        if (cfg.offset_enable) begin
          offset_counter_next = offset_counter + SAMPLE_BITS'(1);
        end
        if (level != stored_level) begin
          stored_level_next = level;
          changed           = 1'b1;
          if (level < cfg.low_threshold) begin
            blink_rem_next   = short_load;
            blink_armed_next = 1'b1;
          end
        end
      end
      OP_PIN: begin
        charger_level_next = present;
        if (cfg.charge_enable) begin
          if (present) begin
            led_state_next    = 1'b0;
            charge_rem_next   = charge_load;
            charge_armed_next = 1'b1;
          end else begin
            led_state_next    = 1'b1;
            charge_rem_next   = '0;
            charge_armed_next = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    result.led_on        = led_state_next;
    result.battery_level = stored_level_next;
    result.level_update  = changed;
    result.battery_low   = stored_level_next < cfg.low_threshold;
    result.charging      = cfg.charge_enable & charger_level_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      led_state      <= 1'b1;
      stored_level   <= '0;
      offset_counter <= '0;
      pulses_left    <= BLINKS_PER_BURST_RESET;
      blink_rem      <= TIMER_BITS'(BLINK_SHORT_RESET);
      blink_armed    <= 1'b1;
      charge_rem     <= '0;
      charge_armed   <= 1'b0;
      charger_level  <= 1'b0;
    end else if (step) begin
      led_state      <= led_state_next;
      stored_level   <= stored_level_next;
      offset_counter <= offset_counter_next;
      pulses_left    <= pulses_left_next;
      blink_rem      <= blink_rem_next;
      blink_armed    <= blink_armed_next;
      charge_rem     <= charge_rem_next;
      charge_armed   <= charge_armed_next;
      charger_level  <= charger_level_next;
    end
  end

`ifndef SYNTHESIS
  a_blink_idle_zero: assert property (@(posedge clk) disable iff (rst)
    !blink_armed |-> blink_rem == '0)
    else $error("blink timer disarmed with count left");

  a_charge_idle_zero: assert property (@(posedge clk) disable iff (rst)
    !charge_armed |-> charge_rem == '0)
    else $error("charge timer disarmed with count left");

  a_hold_without_step: assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable(stored_level) && $stable(offset_counter))
    else $error("level state moved without a beat");
`endif

endmodule

FILE: rtl/battery_level_led_indicator.sv
// ----------------------------------------------------------------------------
// battery_level_led_indicator
// battery level tracking and shared indicator led sequencing
// ----------------------------------------------------------------------------
// usage:
//   event channel (event_valid/event_stall) carries one beat per event:
//   a millisecond tick, an adc sample or a charger pin change.
//   result channel (result_valid/result_stall) returns exactly one beat
//   per event with led, level, update, low and charging flags.
//   configuration registers are written through cfg_write/cfg_index/cfg_data
//   while no events are in flight.
//   an accepted event is registered in the event register, updated against
//   the engine state and stored in the result register as a result beat.
//   throughput: one event per cycle while the result is not stalled, set by the
//   single-pass state update between the event register and the result register.
//   reset: engine state and configuration return to their defaults, the led state is on
//   and the low-battery blink timer is armed; both channels come up empty.
//   a stalled result holds; the event register still fills behind it, and
//   event_stall rises only when both registers are full.
// ----------------------------------------------------------------------------
module battery_level_led_indicator
  import bli_pkg::*;
#(
  parameter int TIMER_BITS = TIMER_BITS_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                      event_valid,
  output logic                      event_stall,
  input  logic [1:0]                operation,
  input  logic [SAMPLE_BITS-1:0]    sample_value,
  input  logic                      charger_present,
  output logic                      result_valid,
  input  logic                      result_stall,
  output logic                      led_on,
  output logic [SAMPLE_BITS-1:0]    battery_level,
  output logic                      level_update,
  output logic                      battery_low,
  output logic                      charging
);

  cfg_t                   cfg;
  result_t                result_comb;
  result_t                result_q;
  logic                   ev_valid;
  logic [1:0]             ev_op;
  logic [SAMPLE_BITS-1:0] ev_sample;
  logic                   ev_present;
  logic                   out_load;
  logic                   step;

  assign out_load    = !result_valid || !result_stall;
  assign step        = ev_valid && out_load;
  assign event_stall = ev_valid && !out_load;

  bli_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bli_engine #(
    .TIMER_BITS (TIMER_BITS)
  ) u_engine (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .step    (step),
    .op      (ev_op),
    .sample  (ev_sample),
    .present (ev_present),
    .result  (result_comb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ev_valid <= 1'b0;
    end else if (!event_stall) begin
      ev_valid <= event_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (event_valid && !event_stall) begin
      ev_op      <= operation;
      ev_sample  <= sample_value;
      ev_present <= charger_present;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= ev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      result_q <= result_comb;
    end
  end

  assign led_on        = result_q.led_on;
  assign battery_level = result_q.battery_level;
  assign level_update  = result_q.level_update;
  assign battery_low   = result_q.battery_low;
  assign charging      = result_q.charging;

`ifndef SYNTHESIS
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !result_valid && !ev_valid)
    else $error("pipeline not empty after reset");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    event_stall |-> result_valid && result_stall && ev_valid)
    else $error("event stalled with room downstream");

  a_step_delivers: assert property (@(posedge clk) disable iff (rst)
    step |=> result_valid)
    else $error("processed event produced no result beat");
`endif

endmodule
